// ===== hw/rtl/sas_pkg.sv =====
`timescale 1ns / 1ps

package sas_pkg;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic [1:0] WALK_NONE  = 2'd0;
	localparam logic [1:0] WALK_RIGHT = 2'd1;
	localparam logic [1:0] WALK_LEFT  = 2'd2;

	localparam logic signed [8:0] X_LO      = -9'sd64;
	localparam logic signed [8:0] X_HI      = 9'sd64;
	localparam logic signed [8:0] X_SPAN    = 9'sd128;
	localparam logic signed [8:0] WALK_EDGE = 9'sd16;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] frame_count;
		logic [5:0] loop_first;
		logic [6:0] loop_last;
		logic       looped;
		logic [7:0] skip_speed;
		logic [7:0] repeat_count;
		logic [5:0] table_index;
		logic [7:0] movement_code;
	} item_t;

	typedef struct packed {
		logic        frame_valid;
		logic [5:0]  frame_index;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic        finished;
		logic [1:0]  walk_request;
		logic [1:0]  walk_repeats;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [5:0] idx;
		logic [7:0] code;
	} tbl_wr_t;

endpackage

// ===== hw/rtl/sas_table.sv =====
`timescale 1ns / 1ps

module sas_table import sas_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  tbl_wr_t    wr,
	input  logic [6:0] rd_addr,
	output logic [7:0] rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic          fwd;

	assign wa  = wr.idx[AW-1:0];
	assign ra  = rd_addr[AW-1:0];
	// write-first on the same entry
	assign fwd = wr.en && (wa == ra);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= wr.code;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= fwd ? wr.code : mem[ra];
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/sas_core.sv =====
`timescale 1ns / 1ps

module sas_core import sas_pkg::*; #(
	parameter int MAX_FRAMES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  item_t      item,
	input  logic [7:0] code_pref,
	output logic [6:0] rd_addr,
	output tbl_wr_t    wr,
	output result_t    res
);

	localparam int          TBL_DEPTH = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
	localparam int          LEN_CAP   = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;
	localparam logic [8:0]  MAX9      = MAX_FRAMES[8:0];
	localparam logic [6:0]  TBL7      = TBL_DEPTH[6:0];
	localparam logic [6:0]  CAP7      = LEN_CAP[6:0];

	logic       running_q,  running_d;
	logic [6:0] frame_pos_q, frame_pos_d;
	logic [7:0] repeats_q,  repeats_d;
	logic [7:0] skip_q,     skip_d;
	logic [7:0] reload_q,   reload_d;
	logic [6:0] len_q,      len_d;
	logic [5:0] wfirst_q,   wfirst_d;
	logic [6:0] wlast_q,    wlast_d;
	logic       wmode_q,    wmode_d;
	logic [7:0] off_x_q,    off_x_d;
	logic [7:0] off_y_q,    off_y_d;

	logic [7:0]        code;
	logic [5:0]        amt;
	logic signed [8:0] x9, xl, xr, xn, nx;
	logic [6:0]        pos, len_in;
	logic              shown, done;
	logic [1:0]        walk, wrep;

	assign code = (frame_pos_q < TBL7) ? code_pref : 8'd0;
	assign amt  = code[5:0];

	always_comb begin
		running_d   = running_q;
		frame_pos_d = frame_pos_q;
		repeats_d   = repeats_q;
		skip_d      = skip_q;
		reload_d    = reload_q;
		len_d       = len_q;
		wfirst_d    = wfirst_q;
		wlast_d     = wlast_q;
		wmode_d     = wmode_q;
		off_x_d     = off_x_q;
		off_y_d     = off_y_q;
		shown       = 1'b0;
		done        = 1'b0;
		walk        = WALK_NONE;
		wrep        = 2'd0;
		wr.en       = 1'b0;
		wr.idx      = item.table_index;
		wr.code     = item.movement_code;

		x9 = {off_x_q[7], off_x_q};
		xl = x9 - $signed({3'b000, amt});
		if (xl < X_LO) begin
			xl = xl + X_SPAN;
		end
		xr = x9 + $signed({3'b000, amt});
		if (xr > X_HI) begin
			xr = xr - X_SPAN;
		end

		len_in = (item.frame_count == 7'd0) ? 7'd1 : item.frame_count;
		if (len_in > CAP7) begin
			len_in = CAP7;
		end

		pos = frame_pos_q + 7'd1;
		if (repeats_q != 8'd0 && wmode_q) begin
			if (pos == wlast_q) begin
				pos = {1'b0, wfirst_q};
			end
		end else if (repeats_q != 8'd0 && pos == len_q) begin
			pos = 7'd0;
		end

		if (accept) begin
			unique case (item.kind)
				KIND_START: begin
					len_d       = len_in;
					wfirst_d    = item.loop_first;
					wlast_d     = item.loop_last;
					wmode_d     = item.looped;
					reload_d    = item.skip_speed;
					skip_d      = item.skip_speed;
					repeats_d   = item.repeat_count;
					frame_pos_d = 7'd0;
					running_d   = 1'b1;
				end
				KIND_LOAD: begin
					wr.en = ({3'b000, item.table_index} < MAX9);
				end
				KIND_TICK: begin
					if (running_q) begin
						if (skip_q != 8'd0) begin
							skip_d = skip_q - 8'd1;
						end else begin
							skip_d = reload_q;
							shown  = 1'b1;
							if (code != 8'd0) begin
								unique case (code[7:6])
									DIR_UP:   off_y_d = off_y_q + {2'b00, amt};
									DIR_DOWN: off_y_d = off_y_q - {2'b00, amt};
									DIR_LEFT: off_x_d = xl[7:0];
									DIR_RIGHT: off_x_d = xr[7:0];
									default:  off_x_d = off_x_q;
								endcase
							end
							if (repeats_q != 8'd0 &&
							    ((wmode_q && frame_pos_q + 7'd1 == wlast_q) ||
							     (!wmode_q && frame_pos_q + 7'd1 == len_q))) begin
								repeats_d = repeats_q - 8'd1;
							end
							frame_pos_d = pos;
							if (pos >= len_q) begin
								done      = 1'b1;
								running_d = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end

		xn = {off_x_d[7], off_x_d};
		nx = -xn;
		if (done) begin
			if (xn < -WALK_EDGE) begin
				walk = WALK_RIGHT;
				wrep = nx[5:4] - 2'd1;
			end else if (xn > WALK_EDGE) begin
				walk = WALK_LEFT;
				wrep = xn[5:4] - 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			frame_pos_q <= 7'd0;
			repeats_q   <= 8'd0;
			skip_q      <= 8'd0;
			reload_q    <= 8'd0;
			len_q       <= 7'd0;
			wfirst_q    <= 6'd0;
			wlast_q     <= 7'd0;
			wmode_q     <= 1'b0;
			off_x_q     <= 8'd0;
			off_y_q     <= 8'd0;
		end else begin
			running_q   <= running_d;
			frame_pos_q <= frame_pos_d;
			repeats_q   <= repeats_d;
			skip_q      <= skip_d;
			reload_q    <= reload_d;
			len_q       <= len_d;
			wfirst_q    <= wfirst_d;
			wlast_q     <= wlast_d;
			wmode_q     <= wmode_d;
			off_x_q     <= off_x_d;
			off_y_q     <= off_y_d;
		end
	end

	// prefetch the entry for the frame that the next tick shows
	assign rd_addr = frame_pos_d;

	assign res.frame_valid  = shown;
	assign res.frame_index  = shown ? frame_pos_q[5:0] : frame_pos_d[5:0];
	assign res.pos_x        = off_x_d;
	assign res.pos_y        = off_y_d;
	assign res.finished     = done;
	assign res.walk_request = walk;
	assign res.walk_repeats = wrep;

endmodule

// ===== hw/rtl/sprite_animation_sequencer.sv =====
`timescale 1ns / 1ps

// Sprite animation sequencer.
// Input stream s_*: one item per handshake; s_tuser selects tick, start or
// table load, s_tdata carries the start and load fields.
// Output stream m_*: exactly one result item per input item, in order.
// m_tuser marks a shown frame, m_tlast marks the end of the animation.
// Throughput: one item per cycle. The movement table is a synchronous RAM
// read ahead, at the frame position the next tick will show; a
// load to that entry is forwarded into the read register.
// A taken item's result is registered into the output register or the skid.
// A two-entry output buffer (output register plus skid) decouples the
// sides: s_tready depends only on the skid being empty, so one more item is
// taken while a result waits; s_tready drops when both entries are full.
// Reset: all sequencing state and offsets clear, no animation runs and
// the output buffer empties. Table contents are undefined until loaded.

module sprite_animation_sequencer import sas_pkg::*; #(
	parameter int MAX_FRAMES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// frame_count, loop_first, loop_last, looped, skip_speed, repeat_count,
	// table_index, movement_code, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// frame_index, pos_x, pos_y, walk_request, walk_repeats, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// frame_valid
	output logic                 m_tuser,
	// finished
	output logic                 m_tlast
);

	localparam int TBL_DEPTH = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;

	item_t      item;
	result_t    res;
	tbl_wr_t    wr;
	logic [6:0] rd_addr;
	logic [7:0] code_pref;
	logic       accept;

	result_t    out_q, skid_q;
	logic       out_v_q, skid_v_q;

	assign item.kind          = s_tuser;
	assign item.frame_count   = s_tdata[6:0];
	assign item.loop_first    = s_tdata[12:7];
	assign item.loop_last     = s_tdata[19:13];
	assign item.looped        = s_tdata[20];
	assign item.skip_speed    = s_tdata[28:21];
	assign item.repeat_count  = s_tdata[36:29];
	assign item.table_index   = s_tdata[42:37];
	assign item.movement_code = s_tdata[50:43];

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;

	sas_table #(.DEPTH(TBL_DEPTH)) u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (code_pref)
	);

	sas_core #(.MAX_FRAMES(MAX_FRAMES)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.code_pref (code_pref),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				out_v_q  <= skid_v_q || accept;
				skid_v_q <= 1'b0;
			end else if (accept) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.frame_valid;
	assign m_tlast  = out_q.finished;
	assign m_tdata  = {6'd0, out_q.walk_repeats, out_q.walk_request,
	                   out_q.pos_y, out_q.pos_x, out_q.frame_index};

endmodule

// ===== hw/rtl/sas_checker.sv =====
`timescale 1ns / 1ps

module sas_checker import sas_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tuser,
	input  logic                 m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_walk_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23:22] != WALK_NONE |-> m_tlast)
		else $error("walk request without completion");

	a_end_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("completion without a shown frame");

	a_reps_need_walk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25:24] != 2'd0 |-> m_tdata[23:22] != WALK_NONE)
		else $error("walk repeats without walk request");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[13:6]) >= -8'sd64 &&
		              $signed(m_tdata[13:6]) <= 8'sd64))
		else $error("pos_x out of range");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
